// ----- hw/rtl/htalloc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htalloc_pkg: shared types and constants of the handle table allocator
// Request codes, status codes, entry layout and used-mark word geometry.
// ----------------------------------------------------------------------------
package htalloc_pkg;

    localparam int OPCODE_W = 2;
    localparam int HINDEX_W = 10;
    localparam int HANDLE_W = 32;
    localparam int KIND_W   = 4;
    localparam int STATUS_W = 2;
    localparam int RINDEX_W = 8;

    // used marks are kept in words of this many bits
    localparam int WORD_BITS  = 32;
    localparam int WORD_SEL_W = 5;
    localparam int BYTE_COUNT = WORD_BITS / 8;
    localparam int BYTE_SEL_W = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ALLOC  = 2'd0,
        OP_GET    = 2'd1,
        OP_UPDATE = 2'd2,
        OP_FREE   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_BAD  = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] server;
        logic [HANDLE_W-1:0] priv;
        logic [KIND_W-1:0]   kind;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic                  found;
        logic [WORD_SEL_W-1:0] pos;
    } scan_res_t;

endpackage

// ----- hw/rtl/htalloc_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htalloc_if: request and response channels of the handle table allocator
// Valid/ready channels; a transaction completes when valid and ready are high.
// ----------------------------------------------------------------------------
interface htalloc_req_if;
    logic                               valid;
    logic                               ready;
    logic [htalloc_pkg::OPCODE_W-1:0]   opcode;
    logic [htalloc_pkg::HINDEX_W-1:0]   handle_index;
    logic [htalloc_pkg::HANDLE_W-1:0]   server_handle;
    logic [htalloc_pkg::HANDLE_W-1:0]   private_handle;
    logic [htalloc_pkg::KIND_W-1:0]     entry_kind;

    modport source (
        output valid, opcode, handle_index, server_handle, private_handle, entry_kind,
        input  ready
    );
    modport sink (
        input  valid, opcode, handle_index, server_handle, private_handle, entry_kind,
        output ready
    );
endinterface

interface htalloc_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [htalloc_pkg::STATUS_W-1:0]   status;
    logic [htalloc_pkg::RINDEX_W-1:0]   result_index;
    logic                               in_use;
    logic [htalloc_pkg::HANDLE_W-1:0]   server_handle_out;
    logic [htalloc_pkg::HANDLE_W-1:0]   private_handle_out;
    logic [htalloc_pkg::KIND_W-1:0]     entry_kind_out;

    modport source (
        output valid, status, result_index, in_use,
               server_handle_out, private_handle_out, entry_kind_out,
        input  ready
    );
    modport sink (
        input  valid, status, result_index, in_use,
               server_handle_out, private_handle_out, entry_kind_out,
        output ready
    );
endinterface

// ----- hw/rtl/htalloc_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htalloc_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module htalloc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/htalloc_ffz.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htalloc_ffz: lowest free slot finder for one used-mark word
// Masks off slots past the end of the table, then picks the first free byte
// and the first free bit within it.
// ----------------------------------------------------------------------------
module htalloc_ffz #(
    parameter int TABLE_SIZE = 256,
    parameter int WORD_AW    = 3
) (
    input  logic [htalloc_pkg::WORD_BITS-1:0] word,
    input  logic [WORD_AW-1:0]                word_addr,
    output htalloc_pkg::scan_res_t            res
);

    localparam int BW = WORD_AW + htalloc_pkg::WORD_SEL_W + 1;

    logic [htalloc_pkg::WORD_BITS-1:0]  avail;
    logic [htalloc_pkg::BYTE_COUNT-1:0] byte_avail;
    logic [BW-1:0]                      base;
    logic [htalloc_pkg::BYTE_SEL_W-1:0] byte_sel;
    logic [7:0]                         byte_bits;
    logic [2:0]                         bit_sel;

    assign base = BW'(word_addr) << htalloc_pkg::WORD_SEL_W;

    always_comb
    begin
        for (int b = 0; b < htalloc_pkg::WORD_BITS; b++)
        begin
            avail[b] = !word[b] && ((base + BW'(b)) < BW'(TABLE_SIZE));
        end
        for (int k = 0; k < htalloc_pkg::BYTE_COUNT; k++)
        begin
            byte_avail[k] = |avail[k*8 +: 8];
        end
    end

    // priority pick: lowest byte first, then lowest bit
    always_comb
    begin
        byte_sel = '0;
        for (int k = htalloc_pkg::BYTE_COUNT - 1; k >= 0; k--)
        begin
            if (byte_avail[k])
            begin
                byte_sel = htalloc_pkg::BYTE_SEL_W'(k);
            end
        end
        byte_bits = avail[byte_sel*8 +: 8];
        bit_sel = '0;
        for (int b = 7; b >= 0; b--)
        begin
            if (byte_bits[b])
            begin
                bit_sel = 3'(b);
            end
        end
        res.found = |byte_avail;
        res.pos   = {byte_sel, bit_sel};
    end

endmodule

// ----- hw/rtl/handle_table_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// handle_table_allocator: lowest-free handle table with allocate/get/update/free
// A table of ROW_COUNT * ENTRIES_PER_ROW entries, each a used mark, two handles
// and a kind code; allocation prefers the hint slot, else the lowest free one.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one request per transaction (opcode, handle_index,
//   server_handle, private_handle, entry_kind); rsp carries exactly one result
//   per request, in request order.
//   Get, update and free pass through the fetch, evaluate and hand-off states
//   (an out-of-range index skips evaluate); one request is handled at a time.
//   Allocate whose hint slot is free goes through fetch, hint check, write and
//   hand-off. When the hint slot is taken or past the table end, the used-mark
//   words are scanned from word 0, one 32-entry word per RAM read and
//   free-slot finder check, and the first word with a free slot supplies the
//   allocated entry; if none has one, the result is a full status.
//   After reset the table RAMs are swept to zero, one entry a cycle, until the
//   last entry is cleared; req.ready stays low throughout.
//   A finished result sits in an output register; the next request is taken
//   while it waits. If rsp is stalled, the following result holds inside the
//   block and req.ready stays low until the output register frees.
// ----------------------------------------------------------------------------
module handle_table_allocator #(
    parameter int ROW_COUNT       = 8,
    parameter int ENTRIES_PER_ROW = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    htalloc_req_if.sink   req,
    htalloc_rsp_if.source rsp
);

    localparam int TABLE_SIZE = ROW_COUNT * ENTRIES_PER_ROW;
    localparam int IDX_W      = TABLE_SIZE > 1 ? $clog2(TABLE_SIZE) : 1;
    localparam int HINT_W     = $clog2(TABLE_SIZE + 1);
    localparam int WORDS      = (TABLE_SIZE + htalloc_pkg::WORD_BITS - 1)
                                / htalloc_pkg::WORD_BITS;
    localparam int WORD_AW    = WORDS > 1 ? $clog2(WORDS) : 1;
    localparam int AW         = IDX_W + htalloc_pkg::WORD_SEL_W;

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_FETCH = 9'b000000100,
        S_EVAL  = 9'b000001000,
        S_HINT  = 9'b000010000,
        S_SCAN  = 9'b000100000,
        S_CHECK = 9'b001000000,
        S_WRITE = 9'b010000000,
        S_RESP  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // request capture
    htalloc_pkg::op_t                   op_reg;
    logic [IDX_W-1:0]                   idx_reg;
    logic [htalloc_pkg::RINDEX_W-1:0]   echo_reg;
    logic                               range_reg;
    htalloc_pkg::entry_t                new_reg;

    logic [HINT_W-1:0]                  hint_reg, hint_next;
    logic [WORD_AW-1:0]                 scan_reg, scan_next;
    logic [IDX_W-1:0]                   clr_reg, clr_next;
    logic [IDX_W-1:0]                   slot_reg, slot_next;
    logic [htalloc_pkg::WORD_BITS-1:0]  word_reg, word_next;

    // staged result, then output register
    htalloc_pkg::status_t               res_status_reg, res_status_next;
    logic [htalloc_pkg::RINDEX_W-1:0]   res_index_reg, res_index_next;
    logic                               res_used_reg, res_used_next;
    htalloc_pkg::entry_t                res_data_reg, res_data_next;

    logic                               out_valid_reg, out_valid_next;
    htalloc_pkg::status_t               out_status_reg;
    logic [htalloc_pkg::RINDEX_W-1:0]   out_index_reg;
    logic                               out_used_reg;
    htalloc_pkg::entry_t                out_data_reg;

    // RAM ports
    logic                               used_we;
    logic [WORD_AW-1:0]                 used_waddr, used_raddr;
    logic [htalloc_pkg::WORD_BITS-1:0]  used_wdata, used_rdata;
    logic                               data_we;
    logic [IDX_W-1:0]                   data_waddr;
    htalloc_pkg::entry_t                data_wdata, data_rdata;

    htalloc_pkg::scan_res_t             scan_res;

    logic                               accept;
    logic                               out_load;
    logic                               hint_ok;
    logic [AW-1:0]                      hint_x, idx_x, slot_x, clr_x, scan_slot_x;
    logic [WORD_AW-1:0]                 hint_word, idx_word, slot_word;
    logic [htalloc_pkg::WORD_SEL_W-1:0] hint_bit, idx_bit, slot_bit;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign out_load  = (state_reg == S_RESP) && (!out_valid_reg || rsp.ready);

    assign hint_x    = AW'(hint_reg);
    assign idx_x     = AW'(idx_reg);
    assign slot_x    = AW'(slot_reg);
    assign clr_x     = AW'(clr_reg);
    assign hint_word = WORD_AW'(hint_x >> htalloc_pkg::WORD_SEL_W);
    assign idx_word  = WORD_AW'(idx_x >> htalloc_pkg::WORD_SEL_W);
    assign slot_word = WORD_AW'(slot_x >> htalloc_pkg::WORD_SEL_W);
    assign hint_bit  = hint_x[htalloc_pkg::WORD_SEL_W-1:0];
    assign idx_bit   = idx_x[htalloc_pkg::WORD_SEL_W-1:0];
    assign slot_bit  = slot_x[htalloc_pkg::WORD_SEL_W-1:0];
    assign hint_ok   = hint_reg < HINT_W'(TABLE_SIZE);
    assign scan_slot_x = (AW'(scan_reg) << htalloc_pkg::WORD_SEL_W) | AW'(scan_res.pos);

    assign used_raddr = (state_reg == S_SCAN) ? scan_reg
                      : (op_reg == htalloc_pkg::OP_ALLOC) ? hint_word : idx_word;

    htalloc_ram #(
        .WIDTH (htalloc_pkg::WORD_BITS),
        .DEPTH (WORDS)
    ) u_used_ram (
        .clk   (clk),
        .we    (used_we),
        .waddr (used_waddr),
        .wdata (used_wdata),
        .raddr (used_raddr),
        .rdata (used_rdata)
    );

    htalloc_ram #(
        .WIDTH (htalloc_pkg::ENTRY_W),
        .DEPTH (TABLE_SIZE)
    ) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (data_waddr),
        .wdata (data_wdata),
        .raddr (idx_reg),
        .rdata (data_rdata)
    );

    htalloc_ffz #(
        .TABLE_SIZE (TABLE_SIZE),
        .WORD_AW    (WORD_AW)
    ) u_ffz (
        .word      (used_rdata),
        .word_addr (scan_reg),
        .res       (scan_res)
    );

    always_comb
    begin
        state_next      = state_reg;
        hint_next       = hint_reg;
        scan_next       = scan_reg;
        clr_next        = clr_reg;
        slot_next       = slot_reg;
        word_next       = word_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        res_used_next   = res_used_reg;
        res_data_next   = res_data_reg;
        used_we         = 1'b0;
        used_waddr      = idx_word;
        used_wdata      = used_rdata & ~(htalloc_pkg::WORD_BITS'(1) << idx_bit);
        data_we         = 1'b0;
        data_waddr      = idx_reg;
        data_wdata      = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                data_we    = 1'b1;
                data_waddr = clr_reg;
                used_we    = clr_x < AW'(WORDS);
                used_waddr = WORD_AW'(clr_reg);
                used_wdata = '0;
                clr_next   = clr_reg + IDX_W'(1);
                if (clr_reg == IDX_W'(TABLE_SIZE - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    scan_next  = '0;
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                if (op_reg == htalloc_pkg::OP_ALLOC)
                begin
                    state_next = hint_ok ? S_HINT : S_SCAN;
                end
                else if (!range_reg)
                begin
                    res_status_next = htalloc_pkg::ST_BAD;
                    res_index_next  = echo_reg;
                    res_used_next   = 1'b0;
                    res_data_next   = '0;
                    state_next      = S_RESP;
                end
                else
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                res_index_next = echo_reg;
                res_status_next = htalloc_pkg::ST_OK;
                res_used_next  = used_rdata[idx_bit];
                res_data_next  = '0;
                state_next     = S_RESP;
                unique case (op_reg)
                    htalloc_pkg::OP_GET:
                    begin
                        res_data_next = data_rdata;
                    end
                    htalloc_pkg::OP_UPDATE:
                    begin
                        data_we    = 1'b1;
                        data_wdata = new_reg;
                    end
                    htalloc_pkg::OP_FREE:
                    begin
                        if (!used_rdata[idx_bit])
                        begin
                            res_status_next = htalloc_pkg::ST_BAD;
                        end
                        else
                        begin
                            res_data_next = data_rdata;
                            data_we       = 1'b1;
                            used_we       = 1'b1;
                            if (hint_x > idx_x)
                            begin
                                hint_next = HINT_W'(idx_reg);
                            end
                        end
                    end
                    default:
                    begin
                        res_status_next = htalloc_pkg::ST_BAD;
                    end
                endcase
            end
            S_HINT:
            begin
                if (!used_rdata[hint_bit])
                begin
                    slot_next  = IDX_W'(hint_reg);
                    word_next  = used_rdata | (htalloc_pkg::WORD_BITS'(1) << hint_bit);
                    state_next = S_WRITE;
                end
                else
                begin
                    // stale hint: fall back to a scan from the bottom
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (scan_res.found)
                begin
                    slot_next  = IDX_W'(scan_slot_x);
                    word_next  = used_rdata | (htalloc_pkg::WORD_BITS'(1) << scan_res.pos);
                    state_next = S_WRITE;
                end
                else if (scan_reg == WORD_AW'(WORDS - 1))
                begin
                    res_status_next = htalloc_pkg::ST_FULL;
                    res_index_next  = '0;
                    res_used_next   = 1'b0;
                    res_data_next   = '0;
                    state_next      = S_RESP;
                end
                else
                begin
                    scan_next  = scan_reg + WORD_AW'(1);
                    state_next = S_SCAN;
                end
            end
            S_WRITE:
            begin
                used_we         = 1'b1;
                used_waddr      = slot_word;
                used_wdata      = word_reg;
                data_we         = 1'b1;
                data_waddr      = slot_reg;
                data_wdata      = new_reg;
                hint_next       = HINT_W'(slot_x + AW'(1));
                res_status_next = htalloc_pkg::ST_OK;
                res_index_next  = htalloc_pkg::RINDEX_W'(slot_reg);
                res_used_next   = 1'b1;
                res_data_next   = '0;
                state_next      = S_RESP;
            end
            S_RESP:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            hint_reg      <= '0;
            scan_reg      <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hint_reg      <= hint_next;
            scan_reg      <= scan_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg         <= htalloc_pkg::op_t'(req.opcode);
            idx_reg        <= IDX_W'(req.handle_index);
            echo_reg       <= htalloc_pkg::RINDEX_W'(req.handle_index);
            range_reg      <= 32'(req.handle_index) < 32'(TABLE_SIZE);
            new_reg.server <= req.server_handle;
            new_reg.priv   <= req.private_handle;
            new_reg.kind   <= req.entry_kind;
        end
        slot_reg       <= slot_next;
        word_reg       <= word_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        res_used_reg   <= res_used_next;
        res_data_reg   <= res_data_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_index_reg  <= res_index_reg;
            out_used_reg   <= res_used_reg;
            out_data_reg   <= res_data_reg;
        end
    end

    assign rsp.valid              = out_valid_reg;
    assign rsp.status             = out_status_reg;
    assign rsp.result_index       = out_index_reg;
    assign rsp.in_use             = out_used_reg;
    assign rsp.server_handle_out  = out_data_reg.server;
    assign rsp.private_handle_out = out_data_reg.priv;
    assign rsp.entry_kind_out     = out_data_reg.kind;

    a_hint_range: assert property (@(posedge clk) disable iff (!rst_n)
        hint_reg <= HINT_W'(TABLE_SIZE))
        else $error("free hint beyond table end");

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !req.ready)
        else $error("request taken during clearing sweep");

    a_alloc_marks_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |-> (word_reg[slot_bit] && (slot_x < AW'(TABLE_SIZE))))
        else $error("allocate writes a slot that is not marked or out of range");

    a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_RESP))
        else $error("result presented without a finished request");

endmodule
